// File: rtl/core/imqm_pkg.sv
`default_nettype none
package imqm_pkg;

  localparam logic [1:0] CMD_ENQUEUE = 2'd0;
  localparam logic [1:0] CMD_DEQUEUE = 2'd1;
  localparam logic [1:0] CMD_REMOVE  = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic clr;      // clearing pass: write null at the sweep index
    logic ld;       // word accepted: latch it and read head/tail/links
    logic ex1;      // first update step
    logic ex2;      // second update step
    logic out_ld;   // load result register
  } imqm_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic out_free;
  } imqm_sts_t;

endpackage
`default_nettype wire

// File: rtl/core/imqm_ctrl.sv
`default_nettype none
module imqm_ctrl
  import imqm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire imqm_sts_t sts,
  output imqm_cmd_t      cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EX1   = 3'd2;
  localparam logic [2:0] S_EX2   = 3'd3;
  localparam logic [2:0] S_HOLD  = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld    = 1'b1;
          state_nxt = S_EX1;
        end
      end
      S_EX1: begin
        cmd.ex1   = 1'b1;
        state_nxt = S_EX2;
      end
      S_EX2: begin
        cmd.ex2 = 1'b1;
        if (sts.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        if (sts.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/core/imqm_dp.sv
`default_nettype none
module imqm_dp
  import imqm_pkg::*;
#(
  parameter  int NUM_THREADS = 64,
  localparam int IW = $clog2(NUM_THREADS + 1),
  localparam int TW = $clog2(NUM_THREADS)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire imqm_cmd_t     cmd,
  output imqm_sts_t          sts,
  input  wire logic [1:0]    in_command,
  input  wire logic [IW-1:0] in_queue_id,
  input  wire logic [TW-1:0] in_thread_id,
  output logic [IW-1:0]      out_popped_thread,
  output logic               out_queue_was_empty,
  output logic               out_valid,
  input  wire logic          out_ready
);

  localparam logic [IW-1:0] NULL_ID = IW'(NUM_THREADS);

  logic [IW-1:0] head_mem [0:NUM_THREADS];
  logic [IW-1:0] tail_mem [0:NUM_THREADS];
  logic [IW-1:0] next_mem [0:NUM_THREADS-1];
  logic [IW-1:0] prev_mem [0:NUM_THREADS-1];

  logic [1:0]    cmd_r;
  logic [IW-1:0] q_r;
  logic [TW-1:0] t_r;
  logic          qok_r, tok_r;
  logic [IW-1:0] h_rd_r, tl_rd_r, nx_rd_r, pv_rd_r;
  logic [IW-1:0] clr_cnt_r;
  logic [IW-1:0] pop_r;
  logic          empty_r;
  logic          out_valid_r;

  // read side
  logic          in_qok, in_tok;
  logic [IW-1:0] rd_q_addr;
  logic [TW-1:0] rd_t_addr, rd_n_addr;
  logic          rd_n_en;

  // decoded step conditions
  logic h_ok, tl_ok, nx_ok, pv_ok;
  logic is_enq, is_deq, is_rem;
  logic [TW-1:0] h_ix, tl_ix, nx_ix, pv_ix;

  // write ports
  logic          hw_en, tw_en, nw_en, pw_en;
  logic [IW-1:0] hw_addr, tw_addr;
  logic [TW-1:0] nw_addr, pw_addr;
  logic [IW-1:0] hw_data, tw_data, nw_data, pw_data;
  logic          clr_thr;

  assign in_qok    = (in_queue_id <= NULL_ID);
  assign in_tok    = (IW'(in_thread_id) < NULL_ID);
  assign rd_q_addr = in_qok ? in_queue_id : '0;
  assign rd_t_addr = in_tok ? in_thread_id : '0;

  assign h_ok  = (h_rd_r  < NULL_ID);
  assign tl_ok = (tl_rd_r < NULL_ID);
  assign nx_ok = (nx_rd_r < NULL_ID);
  assign pv_ok = (pv_rd_r < NULL_ID);
  assign h_ix  = h_rd_r[TW-1:0];
  assign tl_ix = tl_rd_r[TW-1:0];
  assign nx_ix = nx_rd_r[TW-1:0];
  assign pv_ix = pv_rd_r[TW-1:0];

  assign is_enq = (cmd_r == CMD_ENQUEUE) && qok_r && tok_r;
  assign is_deq = (cmd_r == CMD_DEQUEUE) && qok_r;
  assign is_rem = (cmd_r == CMD_REMOVE) && qok_r && tok_r && h_ok;

  // second next-link read fetches the successor of the popped head
  assign rd_n_en   = cmd.ld || (cmd.ex1 && is_deq);
  assign rd_n_addr = cmd.ld ? rd_t_addr : (h_ok ? h_ix : '0);

  assign clr_thr = (clr_cnt_r < NULL_ID);

  always_comb begin
    hw_en = 1'b0; hw_addr = q_r; hw_data = NULL_ID;
    tw_en = 1'b0; tw_addr = q_r; tw_data = NULL_ID;
    nw_en = 1'b0; nw_addr = t_r; nw_data = NULL_ID;
    pw_en = 1'b0; pw_addr = t_r; pw_data = NULL_ID;
    if (cmd.clr) begin
      hw_en   = 1'b1;
      hw_addr = clr_cnt_r;
      tw_en   = 1'b1;
      tw_addr = clr_cnt_r;
      nw_en   = clr_thr;
      nw_addr = clr_cnt_r[TW-1:0];
      pw_en   = clr_thr;
      pw_addr = clr_cnt_r[TW-1:0];
    end else if (cmd.ex1) begin
      if (is_enq) begin
        tw_en   = 1'b1;
        tw_data = IW'(t_r);
        nw_en   = 1'b1;
        pw_en   = 1'b1;
        pw_data = tl_ok ? tl_rd_r : NULL_ID;
        if (!tl_ok) begin
          hw_en   = 1'b1;
          hw_data = IW'(t_r);
        end
      end else if (is_deq) begin
        if (h_ok) begin
          pw_en   = 1'b1;
          pw_addr = h_ix;
        end
      end else if (is_rem) begin
        // join the neighbours around the removed thread
        if (nx_ok) begin
          pw_en   = 1'b1;
          pw_addr = nx_ix;
          pw_data = pv_rd_r;
        end else begin
          tw_en   = 1'b1;
          tw_data = pv_rd_r;
        end
        if (pv_ok) begin
          nw_en   = 1'b1;
          nw_addr = pv_ix;
          nw_data = nx_rd_r;
        end else begin
          hw_en   = 1'b1;
          hw_data = nx_rd_r;
        end
      end
    end else if (cmd.ex2) begin
      if (is_enq) begin
        if (tl_ok) begin
          nw_en   = 1'b1;
          nw_addr = tl_ix;
          nw_data = IW'(t_r);
        end
      end else if (is_deq) begin
        if (h_ok) begin
          hw_en   = 1'b1;
          hw_data = nx_ok ? nx_rd_r : NULL_ID;
          nw_en   = 1'b1;
          nw_addr = h_ix;
          if (nx_ok) begin
            pw_en   = 1'b1;
            pw_addr = nx_ix;
          end else begin
            tw_en = 1'b1;
          end
        end
      end else if (is_rem) begin
        nw_en = 1'b1;
        pw_en = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hw_en) begin
      head_mem[hw_addr] <= hw_data;
    end
    if (cmd.ld) begin
      h_rd_r <= head_mem[rd_q_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (tw_en) begin
      tail_mem[tw_addr] <= tw_data;
    end
    if (cmd.ld) begin
      tl_rd_r <= tail_mem[rd_q_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (nw_en) begin
      next_mem[nw_addr] <= nw_data;
    end
    if (rd_n_en) begin
      nx_rd_r <= next_mem[rd_n_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (pw_en) begin
      prev_mem[pw_addr] <= pw_data;
    end
    if (cmd.ld) begin
      pv_rd_r <= prev_mem[rd_t_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld) begin
      cmd_r <= in_command;
      q_r   <= rd_q_addr;
      t_r   <= in_thread_id;
      qok_r <= in_qok;
      tok_r <= in_tok;
    end
    if (cmd.out_ld) begin
      pop_r   <= (is_deq && h_ok) ? h_rd_r : NULL_ID;
      empty_r <= qok_r ? !h_ok : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cmd.out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.clr_last = (clr_cnt_r == NULL_ID);
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_popped_thread   = pop_r;
  assign out_queue_was_empty = empty_r;
  assign out_valid           = out_valid_r;

endmodule
`default_nettype wire

// File: rtl/core/indexed_multi_queue_manager.sv
`default_nettype none
// Manages NUM_THREADS+1 FIFO queues of thread indices held as doubly linked
// lists in four small memories (head, tail, next link, prev link); the value
// NUM_THREADS is the null index. Each input word carries a command (enqueue
// at tail, dequeue head, remove a named thread), a queue and a thread, and
// yields one output word: the popped thread (null unless a dequeue found an
// entry) and a flag that the queue was empty beforehand. After reset the
// block runs a clearing pass that writes null into every entry, and accepts
// no word until it ends. One word is handled at a time, in turn: accept and
// read, first link update, then second link update with result load, as each
// link memory has a single write port; a result that is not taken holds the
// block until the output register frees.
module indexed_multi_queue_manager
  import imqm_pkg::*;
#(
  parameter  int NUM_THREADS = 64,
  localparam int IW    = $clog2(NUM_THREADS + 1),
  localparam int TW    = $clog2(NUM_THREADS),
  localparam int IN_W  = ((2 + IW + TW + 7) / 8) * 8,
  localparam int OUT_W = ((IW + 1 + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  // command, queue_id, thread_id
  input  wire logic [IN_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  // popped_thread, queue_was_empty
  output logic [OUT_W-1:0]      out_tdata
);

  imqm_cmd_t     cmd;
  imqm_sts_t     sts;
  logic [IW-1:0] popped;
  logic          was_empty;

  imqm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  imqm_dp #(
    .NUM_THREADS (NUM_THREADS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_command          (in_tdata[1:0]),
    .in_queue_id         (in_tdata[2 +: IW]),
    .in_thread_id        (in_tdata[2 + IW +: TW]),
    .out_popped_thread   (popped),
    .out_queue_was_empty (was_empty),
    .out_valid           (out_tvalid),
    .out_ready           (out_tready)
  );

  assign out_tdata = OUT_W'({was_empty, popped});

endmodule
`default_nettype wire
